// File: src/bklc_pkg.sv
// Package for the bounded key list with compaction.
// Holds sizes, the entry type, the operation, status and state codes.
// No dependencies.
package bklc_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SEG_W     = 15;
    localparam int SIDE_W    = 3;
    localparam int POS_W     = 4;
    localparam int OP_W      = 3;
    localparam int RES_IDX_W = 5;
    localparam int TOTAL_W   = 5;
    localparam int STAT_W    = 2;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 16;

    typedef struct packed {
        logic [SEG_W-1:0]  seg;
        logic [SIDE_W-1:0] side;
    } entry_t;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_DEL_IDX  = 3'd1,
        OP_DEL_LAST = 3'd2,
        OP_DEL_KEY  = 3'd3,
        OP_DEL_SEG  = 3'd4,
        OP_FIND     = 3'd5,
        OP_CLEAR    = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// File: src/bounded_key_list_with_compaction_core.sv
// Bounded ordered key list with compaction: top level and only module; uses bklc_pkg.
// Beats that need no walk go from idle straight to the finish state, which loads the
// result register once the output is free; delete at index, key or segment and find
// first walk the entry memory one entry a cycle in the scan state, if the list is not
// empty and, for delete at index, the index is in range. A new beat is taken while a
// result waits. Reset (aresetn low, synchronous) empties the list and drops any result.
module bounded_key_list_with_compaction_core
    import bklc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata: segment[14:0], side[17:15], position[21:18], zero[23:22]
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: opcode[2:0]
    input  logic [OP_W-1:0]     s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m_tdata: result_index[4:0], entry_total[9:5], status[11:10], zero[15:12]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready
);

    // Input field unpacking
    logic [SEG_W-1:0]  in_seg;
    logic [SIDE_W-1:0] in_side;
    logic [POS_W-1:0]  in_pos;
    op_t               in_op;

    assign in_seg  = s_tdata[SEG_W-1:0];
    assign in_side = s_tdata[SEG_W+SIDE_W-1:SEG_W];
    assign in_pos  = s_tdata[SEG_W+SIDE_W+POS_W-1:SEG_W+SIDE_W];
    assign in_op   = op_t'(s_tuser);

    // Entry memory: one write port, one registered read port
    entry_t mem [DEPTH];
    entry_t rdata_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Control and working registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               op_reg, op_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [SIDE_W-1:0] side_reg, side_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  rd_reg, rd_next;      // next entry to read
    logic [CNT_W-1:0]  wr_reg, wr_next;      // next compacted slot
    logic              pend_reg, pend_next;  // rdata_reg holds a live entry
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    status_t           stat_reg, stat_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [RES_IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [TOTAL_W-1:0]   m_total_reg, m_total_next;
    status_t              m_stat_reg, m_stat_next;

    logic out_free;
    logic scan_done;
    logic match_key;
    logic match_seg;
    logic drop;

    assign out_free  = !m_valid_reg || m_tready;
    assign scan_done = (rd_reg == count_reg) && !pend_reg;
    assign match_key = (rdata_reg.seg == seg_reg) && (rdata_reg.side == side_reg);
    assign match_seg = (rdata_reg.seg == seg_reg);

    // Decide whether the entry coming out of memory leaves the list
    always_comb begin
        case (op_reg)
            OP_DEL_IDX: drop = (CMP_W'(pend_idx_reg) == CMP_W'(pos_reg));
            OP_DEL_KEY: drop = match_key && !hit_reg;
            OP_DEL_SEG: drop = match_seg;
            default:    drop = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_op)
                        OP_DEL_IDX: begin
                            state_next = (CMP_W'(in_pos) < CMP_W'(count_reg)) ?
                                         ST_SCAN : ST_FINISH;
                        end
                        OP_DEL_KEY, OP_DEL_SEG, OP_FIND: begin
                            state_next = (count_reg != '0) ? ST_SCAN : ST_FINISH;
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        count_next    = count_reg;
        op_next       = op_reg;
        seg_next      = seg_reg;
        side_next     = side_reg;
        pos_next      = pos_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        idx_next      = idx_reg;
        stat_next     = stat_reg;
        mem_we        = 1'b0;
        mem_waddr     = wr_reg[IDX_W-1:0];
        mem_wdata     = rdata_reg;
        mem_re        = 1'b0;
        mem_raddr     = rd_reg[IDX_W-1:0];
        m_valid_next  = m_valid_reg && !m_tready;
        m_idx_next    = m_idx_reg;
        m_total_next  = m_total_reg;
        m_stat_next   = m_stat_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next   = in_op;
                    seg_next  = in_seg;
                    side_next = in_side;
                    pos_next  = in_pos;
                    rd_next   = '0;
                    wr_next   = '0;
                    hit_next  = 1'b0;
                    idx_next  = '0;
                    stat_next = STAT_MISS;
                    case (in_op)
                        OP_APPEND: begin
                            if (count_reg < CNT_W'(DEPTH)) begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = '{seg: in_seg, side: in_side};
                                hit_next   = 1'b1;
                                idx_next   = count_reg[IDX_W-1:0];
                                stat_next  = STAT_OK;
                                count_next = count_reg + 1'b1;
                            end else begin
                                stat_next = STAT_FULL;
                            end
                        end
                        OP_DEL_IDX: begin
                            // Index is known up front; the walk only compacts
                            if (CMP_W'(in_pos) < CMP_W'(count_reg)) begin
                                hit_next = 1'b1;
                                idx_next = IDX_W'(in_pos);
                            end
                        end
                        OP_DEL_LAST: begin
                            if (count_reg != '0) begin
                                hit_next   = 1'b1;
                                idx_next   = IDX_W'(count_reg - 1'b1);
                                stat_next  = STAT_OK;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            stat_next  = STAT_OK;
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue the next read, one entry a cycle
                if (rd_reg != count_reg) begin
                    mem_re        = 1'b1;
                    rd_next       = rd_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_reg[IDX_W-1:0];
                end
                // Retire the entry read last cycle: keep it or drop it.
                // Writes trail reads, so no slot is overwritten before it is read.
                if (pend_reg) begin
                    if (op_reg == OP_FIND) begin
                        if (match_key && !hit_reg) begin
                            hit_next = 1'b1;
                            idx_next = pend_idx_reg;
                        end
                    end else if (drop) begin
                        if (op_reg != OP_DEL_IDX) begin
                            hit_next = 1'b1;
                            idx_next = pend_idx_reg;  // delete segment ends on the highest
                        end
                    end else begin
                        mem_we  = 1'b1;
                        wr_next = wr_reg + 1'b1;
                    end
                end
                if (scan_done) begin
                    stat_next = hit_reg ? STAT_OK : STAT_MISS;
                    if (op_reg != OP_FIND) begin
                        count_next = wr_reg;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = hit_reg ? RES_IDX_W'(idx_reg) : '1;
                    m_total_next = TOTAL_W'(count_reg);
                    m_stat_next  = stat_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        seg_reg      <= seg_next;
        side_reg     <= side_next;
        pos_reg      <= pos_next;
        rd_reg       <= rd_next;
        wr_reg       <= wr_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        idx_reg      <= idx_next;
        stat_reg     <= stat_next;
        m_idx_reg    <= m_idx_next;
        m_total_reg  <= m_total_next;
        m_stat_reg   <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_IDX_W - TOTAL_W - STAT_W){1'b0}},
                       m_stat_reg, m_total_reg, m_idx_reg};

    // The list never grows past its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Compaction writes never overtake the read pointer
    a_wr_behind_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (wr_reg <= rd_reg))
        else $error("compaction write ahead of read");

    // No entry left in flight when a new beat can be taken
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("read pending while idle");

    // A result is loaded only from the finish step
    a_load_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result loaded outside finish");

    // A miss always reports index -1
    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_stat_reg == STAT_MISS)) |-> (m_idx_reg == '1))
        else $error("miss with a valid index");

endmodule
